// ===== src/vmam_pkg.sv =====
// Shared types and constants for the video memory address map.
// Depends on nothing; the interfaces, core, decoder and bench refer to it by scoped names.
package vmam_pkg;

    localparam int TABLE_BYTES     = 1024;
    localparam int PALETTE_ENTRIES = 32;

    localparam int NT_DEPTH = 2 * TABLE_BYTES;
    localparam int TBL_AW   = $clog2(TABLE_BYTES);
    localparam int NT_AW    = $clog2(NT_DEPTH);
    localparam int PAL_AW   = $clog2(PALETTE_ENTRIES);

    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int TGT_W   = 2;
    localparam int LOC_W   = 13;
    localparam int SPACE_W = 14;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [ADDR_W-1:0] STEP_ONE = 16'd1;
    localparam logic [ADDR_W-1:0] STEP_ROW = 16'd32;

    // first palette row in the folded space: 0x3F00 >> 8
    localparam logic [5:0] PALETTE_PAGE = 6'h3F;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2
    } cmd_t;

    typedef enum logic [TGT_W-1:0] {
        TGT_PATTERN   = 2'd0,
        TGT_NAMETABLE = 2'd1,
        TGT_PALETTE   = 2'd2
    } target_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIRROR_HORIZONTAL = 1'd0,
        REG_STEP_BY_ROW       = 1'd1
    } reg_idx_t;

    typedef struct packed {
        target_t          target;
        logic [LOC_W-1:0] location;
    } decode_t;

endpackage

// ===== src/vmam_if.sv =====
// Request and response channels of the video memory address map.
// Depends on vmam_pkg for field widths.
interface vmam_req_if;
    logic                           valid;
    logic                           ready;
    logic [vmam_pkg::CMD_W-1:0]     command;
    logic [vmam_pkg::ADDR_W-1:0]    address;
    logic [vmam_pkg::DATA_W-1:0]    write_data;
    logic                           advance;

    modport source (output valid, command, address, write_data, advance, input ready);
    modport sink   (input valid, command, address, write_data, advance, output ready);
endinterface

interface vmam_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [vmam_pkg::DATA_W-1:0]    read_data;
    logic [vmam_pkg::TGT_W-1:0]     target;
    logic [vmam_pkg::LOC_W-1:0]     location;
    logic [vmam_pkg::ADDR_W-1:0]    pointer_value;

    modport source (output valid, read_data, target, location, pointer_value, input ready);
    modport sink   (input valid, read_data, target, location, pointer_value, output ready);
endinterface

// ===== src/video_memory_address_map_core.sv =====
// Top level of the video memory address map: decode, stores, pointer, result register.
// Depends on vmam_pkg, vmam_if, vmam_ram and vmam_decode.
//
//  channel  role    beat                                         handshake
//  req      sink    command, address, write_data, advance        valid/ready
//  rsp      source  read_data, target, location, pointer_value   valid/ready
//  cfg      write   cfg_index, cfg_data                          cfg_write_en
//
// One beat per cycle while req.ready is high; a result appears in the cycle after its
// request beat, taken from the result register and the registered read of the store RAMs.
// After reset the nametable and palette RAMs are zeroed one address per cycle;
// req.ready stays low until that pass ends.
// A stalled result holds in the result register and blocks only new beats.
module video_memory_address_map_core (
    input  logic                              clk,
    input  logic                              rst_n,
    vmam_req_if.sink                          req,
    vmam_rsp_if.source                        rsp,
    input  logic                              cfg_write_en,
    input  logic [vmam_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vmam_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NT_AW  = vmam_pkg::NT_AW;
    localparam int PAL_AW = vmam_pkg::PAL_AW;
    localparam int DATA_W = vmam_pkg::DATA_W;
    localparam int ADDR_W = vmam_pkg::ADDR_W;

    logic [NT_AW:0]         clr_cnt_reg;
    logic                   clearing;
    logic                   mirror_reg;
    logic                   step_reg;
    logic [ADDR_W-1:0]      pointer_reg;
    logic [ADDR_W-1:0]      pointer_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   rd_nt_reg;
    logic                   rd_pal_reg;
    vmam_pkg::decode_t      dec;
    vmam_pkg::decode_t      res_reg;
    vmam_pkg::decode_t      res_next;

    logic                   accept;
    logic                   is_read;
    logic                   is_write;
    logic                   is_rw;
    logic                   hit_nt;
    logic                   hit_pal;

    logic                   nt_we;
    logic                   nt_re;
    logic [NT_AW-1:0]       nt_addr;
    logic [DATA_W-1:0]      nt_wdata;
    logic [DATA_W-1:0]      nt_rdata;
    logic                   pal_we;
    logic                   pal_re;
    logic [PAL_AW-1:0]      pal_addr;
    logic [DATA_W-1:0]      pal_wdata;
    logic [DATA_W-1:0]      pal_rdata;

    assign clearing  = !clr_cnt_reg[NT_AW];
    assign req.ready = !clearing && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign is_read  = (req.command == vmam_pkg::CMD_READ);
    assign is_write = (req.command == vmam_pkg::CMD_WRITE);
    assign is_rw    = is_read || is_write;

    vmam_decode u_decode (
        .address           (req.address[vmam_pkg::SPACE_W-1:0]),
        .mirror_horizontal (mirror_reg),
        .dec               (dec)
    );

    assign hit_nt  = (dec.target == vmam_pkg::TGT_NAMETABLE);
    assign hit_pal = (dec.target == vmam_pkg::TGT_PALETTE);

    // store ports: the clearing pass owns them until it ends
    assign nt_we     = clearing || (accept && is_write && hit_nt);
    assign nt_re     = accept && is_read && hit_nt;
    assign nt_addr   = clearing ? clr_cnt_reg[NT_AW-1:0] : dec.location[NT_AW-1:0];
    assign nt_wdata  = clearing ? '0 : req.write_data;
    assign pal_we    = clearing || (accept && is_write && hit_pal);
    assign pal_re    = accept && is_read && hit_pal;
    assign pal_addr  = clearing ? clr_cnt_reg[PAL_AW-1:0] : dec.location[PAL_AW-1:0];
    assign pal_wdata = clearing ? '0 : req.write_data;

    vmam_ram #(
        .WIDTH (DATA_W),
        .DEPTH (vmam_pkg::NT_DEPTH)
    ) u_nt_ram (
        .clk   (clk),
        .we    (nt_we),
        .re    (nt_re),
        .addr  (nt_addr),
        .wdata (nt_wdata),
        .rdata (nt_rdata)
    );

    vmam_ram #(
        .WIDTH (DATA_W),
        .DEPTH (vmam_pkg::PALETTE_ENTRIES)
    ) u_pal_ram (
        .clk   (clk),
        .we    (pal_we),
        .re    (pal_re),
        .addr  (pal_addr),
        .wdata (pal_wdata),
        .rdata (pal_rdata)
    );

    always_comb
    begin
        pointer_next = pointer_reg;
        if (accept)
        begin
            if (is_rw && req.advance)
            begin
                pointer_next = pointer_reg + (step_reg ? vmam_pkg::STEP_ROW
                                                       : vmam_pkg::STEP_ONE);
            end
            else if (req.command == vmam_pkg::CMD_LOAD)
            begin
                pointer_next = req.address;
            end
        end

        if (is_rw)
        begin
            res_next = dec;
        end
        else
        begin
            res_next.target   = vmam_pkg::TGT_PATTERN;
            res_next.location = '0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            mirror_reg    <= 1'b0;
            step_reg      <= 1'b0;
            pointer_reg   <= '0;
            out_valid_reg <= 1'b0;
            rd_nt_reg     <= 1'b0;
            rd_pal_reg    <= 1'b0;
        end
        else
        begin
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    vmam_pkg::REG_MIRROR_HORIZONTAL: mirror_reg <= cfg_data[0];
                    vmam_pkg::REG_STEP_BY_ROW:       step_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            pointer_reg   <= pointer_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                rd_nt_reg  <= is_read && hit_nt;
                rd_pal_reg <= is_read && hit_pal;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = rd_nt_reg  ? nt_rdata  :
                               rd_pal_reg ? pal_rdata : '0;
    assign rsp.target        = res_reg.target;
    assign rsp.location      = res_reg.location;
    assign rsp.pointer_value = pointer_reg;

    a_no_beat_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> !req.ready
    ) else $error("request beat offered ready during clearing pass");

    a_stall_blocks_req: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !req.ready
    ) else $error("request taken while result is stalled");

    a_load_pointer: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.command == vmam_pkg::CMD_LOAD))
        |=> (rsp.valid && (rsp.pointer_value == $past(req.address))
             && (rsp.read_data == '0))
    ) else $error("pointer load result wrong");

    a_palette_alias: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.target == vmam_pkg::TGT_PALETTE))
        |-> ((rsp.location[vmam_pkg::LOC_W-1:PAL_AW] == '0)
             && !(rsp.location[4] && (rsp.location[1:0] == 2'b00)))
    ) else $error("palette location not folded");

endmodule

// ===== src/vmam_ram.sv =====
// Generic single-port RAM with registered read data.
// Standalone; used for the nametable and palette stores.
module vmam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/vmam_decode.sv =====
// Address decoder: folded 14-bit address to target and location.
// Depends on vmam_pkg for the decode_t result.
module vmam_decode (
    input  logic [vmam_pkg::SPACE_W-1:0] address,
    input  logic                         mirror_horizontal,
    output vmam_pkg::decode_t            dec
);

    logic                           phys;
    logic [vmam_pkg::PAL_AW-1:0]    pal_idx;

    always_comb
    begin
        // tables sit in bits 11:10 of the offset from 0x2000
        phys = mirror_horizontal ? address[11] : address[10];

        // upper-row backdrop entries alias the row below
        pal_idx = address[vmam_pkg::PAL_AW-1:0];
        if (pal_idx[4] && (pal_idx[1:0] == 2'b00))
        begin
            pal_idx[4] = 1'b0;
        end

        if (!address[13])
        begin
            dec.target   = vmam_pkg::TGT_PATTERN;
            dec.location = address[vmam_pkg::LOC_W-1:0];
        end
        else if (address[13:8] != vmam_pkg::PALETTE_PAGE)
        begin
            dec.target   = vmam_pkg::TGT_NAMETABLE;
            dec.location = {{(vmam_pkg::LOC_W-vmam_pkg::NT_AW){1'b0}},
                            phys, address[vmam_pkg::TBL_AW-1:0]};
        end
        else
        begin
            dec.target   = vmam_pkg::TGT_PALETTE;
            dec.location = {{(vmam_pkg::LOC_W-vmam_pkg::PAL_AW){1'b0}}, pal_idx};
        end
    end

endmodule

// ===== tb/video_memory_address_map_core_tb.sv =====
// Self-checking bench for video_memory_address_map_core: random and directed beats
// checked against an in-bench model of the stores, mirroring, palette alias and pointer.
// Depends on vmam_pkg, vmam_if and the core RTL.
module video_memory_address_map_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CMD_W      = vmam_pkg::CMD_W;
    localparam int ADDR_W     = vmam_pkg::ADDR_W;
    localparam int DATA_W     = vmam_pkg::DATA_W;
    localparam int LOC_W      = vmam_pkg::LOC_W;
    localparam int SPACE_W    = vmam_pkg::SPACE_W;
    localparam int PAL_AW     = vmam_pkg::PAL_AW;
    localparam int NT_AW      = vmam_pkg::NT_AW;
    localparam int CFG_IDX_W  = vmam_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = vmam_pkg::CFG_DATA_W;

    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
    localparam int               CYCLE_LIMIT  = 400000;
    localparam int               HOLD_CYCLES  = 300;
    localparam int               PHASE_ITEMS  = 125;
    localparam int               PHASE_COUNT  = 8;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic              advance;
    } vram_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        vmam_pkg::target_t  target;
        logic [LOC_W-1:0]   location;
        logic [ADDR_W-1:0]  pointer_value;
    } vram_rsp_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vmam_req_if req_ch();
    vmam_rsp_if rsp_ch();

    video_memory_address_map_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // model state
    logic [DATA_W-1:0] nt_store [vmam_pkg::NT_DEPTH];
    logic [DATA_W-1:0] pal_store [vmam_pkg::PALETTE_ENTRIES];
    logic [ADDR_W-1:0] ptr_model;
    logic              mirror_h_model;
    logic              step_row_model;

    vram_req_t vram_requests [$];
    vram_rsp_t vram_results_due [$];

    int mismatch_count;
    int cycle_count;
    int items_sent;
    int send_gap;
    bit send_calm;
    int rsp_beats;
    int recv_wait;
    bit recv_calm;
    vram_req_t seen_req;
    vram_req_t next_req;
    vram_rsp_t got_rsp;
    vram_rsp_t want_rsp;

    function automatic vram_rsp_t access_vram(vram_req_t r);
        vram_rsp_t          res;
        logic [SPACE_W-1:0] folded;
        logic [1:0]         tbl;
        logic               phys;
        logic [PAL_AW-1:0]  pidx;
        res = '0;
        folded = r.address[SPACE_W-1:0];
        if (r.command == vmam_pkg::CMD_READ || r.command == vmam_pkg::CMD_WRITE)
        begin
            if (folded < 14'h2000)
            begin
                res.target = vmam_pkg::TGT_PATTERN;
                res.location = folded[LOC_W-1:0];
            end
            else if (folded < 14'h3F00)
            begin
                // 0x3000-0x3EFF lands on 0x2000-0x2EFF through the 12-bit offset
                tbl = folded[11:10];
                phys = mirror_h_model ? tbl[1] : tbl[0];
                res.target = vmam_pkg::TGT_NAMETABLE;
                res.location = {2'b00, phys, folded[9:0]};
                if (r.command == vmam_pkg::CMD_READ)
                    res.read_data = nt_store[res.location[NT_AW-1:0]];
                else
                    nt_store[res.location[NT_AW-1:0]] = r.write_data;
            end
            else
            begin
                pidx = folded[PAL_AW-1:0];
                // backdrop entries of the sprite half fold onto the background half
                if (pidx[4] && pidx[1:0] == 2'b00)
                    pidx[4] = 1'b0;
                res.target = vmam_pkg::TGT_PALETTE;
                res.location = {8'd0, pidx};
                if (r.command == vmam_pkg::CMD_READ)
                    res.read_data = pal_store[pidx];
                else
                    pal_store[pidx] = r.write_data;
            end
            if (r.advance)
                ptr_model = ptr_model + (step_row_model ? vmam_pkg::STEP_ROW
                                                        : vmam_pkg::STEP_ONE);
        end
        else if (r.command == vmam_pkg::CMD_LOAD)
        begin
            ptr_model = r.address;
        end
        res.pointer_value = ptr_model;
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        logic [2:0]        tbl;
        tbl = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 4))
            0: a = 16'($urandom_range(0, 16'hFFFF));
            1: a = 16'($urandom_range(0, 16'h1FFF));
            // few offsets per table so reads find earlier writes
            2: a = 16'h2000 + 16'({tbl, 10'd0}) + 16'($urandom_range(0, 15));
            3: a = 16'h3F00 + 16'($urandom_range(0, 255));
            default: a = 16'h2000 + 16'($urandom_range(0, 16'h1EFF));
        endcase
        a[15:14] = 2'($urandom_range(0, 3));
        return a;
    endfunction

    task automatic add_req(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                           logic [DATA_W-1:0] wdata, logic adv);
        vram_req_t r;
        r.command = cmd;
        r.address = addr;
        r.write_data = wdata;
        r.advance = adv;
        vram_requests.push_back(r);
    endtask

    task automatic add_random_reqs(int count);
        int               i;
        int               pick;
        logic [CMD_W-1:0] cmd;
        for (i = 0; i < count; i++)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 40)
                cmd = vmam_pkg::CMD_READ;
            else if (pick < 75)
                cmd = vmam_pkg::CMD_WRITE;
            else if (pick < 90)
                cmd = vmam_pkg::CMD_LOAD;
            else
                cmd = CMD_UNUSED;
            add_req(cmd, pick_address(), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
    endtask

    task automatic write_reg(vmam_pkg::reg_idx_t idx, logic val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == vmam_pkg::REG_MIRROR_HORIZONTAL)
            mirror_h_model = val;
        else
            step_row_model = val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (vram_requests.size() != 0 || req_ch.valid || vram_results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.command <= vmam_pkg::CMD_READ;
            req_ch.address <= '0;
            req_ch.write_data <= '0;
            req_ch.advance <= 1'b0;
            send_gap = 0;
            send_calm = 1'b0;
            items_sent = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                seen_req.command = req_ch.command;
                seen_req.address = req_ch.address;
                seen_req.write_data = req_ch.write_data;
                seen_req.advance = req_ch.advance;
                vram_results_due.push_back(access_vram(seen_req));
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap = send_gap - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (vram_requests.size() != 0)
                begin
                    next_req = vram_requests.pop_front();
                    req_ch.command <= next_req.command;
                    req_ch.address <= next_req.address;
                    req_ch.write_data <= next_req.write_data;
                    req_ch.advance <= next_req.advance;
                    req_ch.valid <= 1'b1;
                    items_sent = items_sent + 1;
                    if (items_sent % 64 == 0)
                        send_calm = ($urandom_range(0, 3) == 0);
                    send_gap = send_calm ? 0 : int'($urandom_range(0, 18));
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_wait = 0;
            recv_calm = 1'b0;
            rsp_beats = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_rsp.read_data = rsp_ch.read_data;
                got_rsp.target = vmam_pkg::target_t'(rsp_ch.target);
                got_rsp.location = rsp_ch.location;
                got_rsp.pointer_value = rsp_ch.pointer_value;
                if (vram_results_due.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: data %h target %0d loc %h ptr %h",
                                 got_rsp.read_data, got_rsp.target, got_rsp.location,
                                 got_rsp.pointer_value);
                end
                else
                begin
                    want_rsp = vram_results_due.pop_front();
                    if (got_rsp.read_data !== want_rsp.read_data
                        || got_rsp.target !== want_rsp.target
                        || got_rsp.location !== want_rsp.location
                        || got_rsp.pointer_value !== want_rsp.pointer_value)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display({"result %0d mismatch: ",
                                      "exp data %h target %0d loc %h ptr %h, ",
                                      "got data %h target %0d loc %h ptr %h"},
                                     rsp_beats, want_rsp.read_data, want_rsp.target,
                                     want_rsp.location, want_rsp.pointer_value,
                                     got_rsp.read_data, got_rsp.target, got_rsp.location,
                                     got_rsp.pointer_value);
                    end
                end
                rsp_beats = rsp_beats + 1;
                if (rsp_beats % 64 == 0)
                    recv_calm = ($urandom_range(0, 3) == 0);
                // long hold-off lets requests pile up behind the result register
                if (rsp_beats % 500 == 150)
                    recv_wait = HOLD_CYCLES;
                else
                    recv_wait = recv_calm ? 0 : int'($urandom_range(0, 18));
            end
            else if (recv_wait != 0)
            begin
                recv_wait = recv_wait - 1;
            end
            rsp_ch.ready <= (recv_wait == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int  ph;
        bit  mh;
        bit  sr;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = vmam_pkg::REG_MIRROR_HORIZONTAL;
        cfg_data = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = vmam_pkg::CMD_READ;
        req_ch.address = '0;
        req_ch.write_data = '0;
        req_ch.advance = 1'b0;
        rsp_ch.ready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        foreach (nt_store[i])
            nt_store[i] = '0;
        foreach (pal_store[i])
            pal_store[i] = '0;
        ptr_model = '0;
        mirror_h_model = 1'b0;
        step_row_model = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0: begin mh = 1'b0; sr = 1'b0; end
                1: begin mh = 1'b1; sr = 1'b1; end
                2: begin mh = 1'b1; sr = 1'b0; end
                3: begin mh = 1'b0; sr = 1'b1; end
                default:
                begin
                    mh = 1'($urandom_range(0, 1));
                    sr = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(vmam_pkg::REG_MIRROR_HORIZONTAL, mh);
            write_reg(vmam_pkg::REG_STEP_BY_ROW, sr);
            if (ph == 0)
            begin
                add_req(vmam_pkg::CMD_READ,  16'h0000, 8'h00, 1'b0);
                add_req(vmam_pkg::CMD_WRITE, 16'h1FFF, 8'hFF, 1'b1);  // pattern write is dropped
                add_req(vmam_pkg::CMD_READ,  16'h1FFF, 8'h00, 1'b0);
                add_req(vmam_pkg::CMD_WRITE, 16'h2000, 8'hFF, 1'b0);
                add_req(vmam_pkg::CMD_READ,  16'h3000, 8'h00, 1'b0);  // upper mirror of 0x2000
                add_req(vmam_pkg::CMD_WRITE, 16'h2400, 8'hA5, 1'b0);
                add_req(vmam_pkg::CMD_READ,  16'h2C00, 8'h00, 1'b0);  // vertical: table 3 on RAM 1
                add_req(vmam_pkg::CMD_WRITE, 16'h3EFF, 8'h5A, 1'b0);
                add_req(vmam_pkg::CMD_READ,  16'h2EFF, 8'h00, 1'b0);
                add_req(vmam_pkg::CMD_WRITE, 16'h3F10, 8'h3C, 1'b0);
                add_req(vmam_pkg::CMD_READ,  16'h3F00, 8'h00, 1'b0);  // palette alias
                add_req(vmam_pkg::CMD_WRITE, 16'h3F1C, 8'hC3, 1'b0);
                add_req(vmam_pkg::CMD_READ,  16'h3F0C, 8'h00, 1'b0);
                add_req(vmam_pkg::CMD_READ,  16'h3F11, 8'h00, 1'b0);
                add_req(vmam_pkg::CMD_READ,  16'hFFFF, 8'h00, 1'b1);  // folds to 0x3FFF
                add_req(vmam_pkg::CMD_READ,  16'hC000, 8'h00, 1'b0);  // folds to 0x0000
                add_req(vmam_pkg::CMD_LOAD,  16'hFFFF, 8'h00, 1'b1);
                add_req(vmam_pkg::CMD_READ,  16'h8000, 8'h00, 1'b1);  // pointer wraps to zero
                add_req(CMD_UNUSED,          16'h2000, 8'hFF, 1'b1);
                add_req(vmam_pkg::CMD_WRITE, 16'h23FF, 8'h00, 1'b1);
            end
            else if (ph == 1)
            begin
                add_req(vmam_pkg::CMD_LOAD,  16'hFFF0, 8'h00, 1'b0);
                add_req(vmam_pkg::CMD_WRITE, 16'h2800, 8'h77, 1'b1);  // row step wraps past 0xFFFF
                add_req(vmam_pkg::CMD_READ,  16'h2400, 8'h00, 1'b1);  // horizontal: table 1 on RAM 0
                add_req(vmam_pkg::CMD_READ,  16'h2C00, 8'h00, 1'b1);
            end
            add_random_reqs(PHASE_ITEMS);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && vram_results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
